// ===== sv/omni_three_wheel_kinematics_core_defines.svh =====
// Assertion macros shared by the kinematics core modules.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef OMNI_THREE_WHEEL_KINEMATICS_CORE_DEFINES_SVH
`define OMNI_THREE_WHEEL_KINEMATICS_CORE_DEFINES_SVH

// The condition must hold at every clock edge.
`define OMNI3_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define OMNI3_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OMNI3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/omni3_pkg.sv =====
`timescale 1ns / 1ps

package omni3_pkg;

    // Field and register widths.
    localparam int AXIS_W  = 8;
    localparam int DZ_W    = 7;
    localparam int ARM_W   = 10;
    localparam int LIM_W   = 10;
    localparam int SPEED_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Register reset values.
    localparam logic [DZ_W-1:0]  DEAD_ZONE_RST   = 7'd50;
    localparam logic [ARM_W-1:0] ARM_LENGTH_RST  = 10'd310;
    localparam logic [LIM_W-1:0] SPEED_LIMIT_RST = 10'd800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEAD_ZONE   = 2'd0,
        CFG_ARM_LENGTH  = 2'd1,
        CFG_SPEED_LIMIT = 2'd2
    } cfg_idx_t;

    // Axis scaling by 950/127 is split into 7 + 61/127. The fractional part uses a
    // reciprocal of 127 that is exact for every product 61*m with m up to 128.
    localparam int SCALE_NUM   = 950;
    localparam int SCALE_DEN   = 127;
    localparam int SCALE_INT   = SCALE_NUM / SCALE_DEN;
    localparam int SCALE_REM   = SCALE_NUM % SCALE_DEN;
    localparam int SCALE_SHIFT = 20;
    localparam int SCALE_RECIP = SCALE_REM * ((2**SCALE_SHIFT + SCALE_DEN - 1) / SCALE_DEN);
    localparam int SCALE_PROD_W = 27;
    localparam int SCALE_MAX   = (2**(AXIS_W-1) * SCALE_NUM) / SCALE_DEN;
    localparam int SCALED_W    = 11;

    // Rotation coefficients in Q1.16; the half coefficient is a shift.
    localparam logic signed [17:0] COS30_Q16 = 18'sd56756;
    localparam int HALF_SHIFT = 15;
    localparam int ONE_SHIFT  = 16;
    localparam int FRAC_W     = 32;

    localparam int ROT_W   = 28;
    localparam int TURN_W  = 21;
    localparam int PROD_W  = 44;
    localparam int SUM_W   = 54;
    localparam int WHOLE_W = SUM_W - FRAC_W;

    typedef struct packed {
        logic              neg;
        logic [AXIS_W-1:0] mag;
    } axis_dz_t;

    typedef struct packed {
        axis_dz_t lx;
        axis_dz_t ly;
        axis_dz_t rx;
    } axes_dz_t;

    typedef struct packed {
        logic signed [SCALED_W-1:0] lx;
        logic signed [SCALED_W-1:0] ly;
        logic signed [SCALED_W-1:0] rx;
    } axes_t;

    typedef struct packed {
        logic signed [ROT_W-1:0]  vx;
        logic signed [ROT_W-1:0]  vy;
        logic signed [TURN_W-1:0] turn;
    } rot_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] cvy;
        logic signed [PROD_W-1:0] hvx;
        logic signed [PROD_W-1:0] vxs;
        logic signed [TURN_W-1:0] turn;
    } prod_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] front;
        logic signed [SUM_W-1:0] rear_right;
        logic signed [SUM_W-1:0] rear_left;
    } wsum_t;

    typedef struct packed {
        logic               rev;
        logic [SPEED_W-1:0] speed;
    } wheel_t;

    typedef struct packed {
        wheel_t front;
        wheel_t rear_right;
        wheel_t rear_left;
    } wheels_t;

endpackage

// ===== sv/omni3_axis_cond.sv =====
`timescale 1ns / 1ps
`include "omni_three_wheel_kinematics_core_defines.svh"

module omni3_axis_cond import omni3_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [DZ_W-1:0]          dead_zone,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [AXIS_W-1:0] lx,
    input  logic signed [AXIS_W-1:0] ly,
    input  logic signed [AXIS_W-1:0] rx,
    output logic                     out_valid,
    input  logic                     out_ready,
    output axes_t                    out_axes
);

    // Stage 1 applies the dead zone, stage 2 scales the magnitudes.
    logic     s1_valid_reg;
    logic     s1_ready;
    axes_dz_t s1_reg;
    axes_dz_t s1_next;
    logic     s2_valid_reg;
    logic     s2_ready;
    axes_t    s2_reg;
    axes_t    s2_next;

    function automatic axis_dz_t dead_band(input logic signed [AXIS_W-1:0] v,
                                           input logic [DZ_W-1:0] dz,
                                           input logic shift);
        axis_dz_t          r;
        logic [AXIS_W-1:0] mag;
        logic [AXIS_W-1:0] dz_e;
        mag   = v[AXIS_W-1] ? AXIS_W'(-v) : AXIS_W'(v);
        dz_e  = AXIS_W'(dz);
        r.neg = v[AXIS_W-1];
        if (mag < dz_e) begin
            r.mag = '0;
        end else if (shift) begin
            r.mag = mag - dz_e;
        end else begin
            r.mag = mag;
        end
        return r;
    endfunction

    function automatic logic signed [SCALED_W-1:0] scale_axis(input axis_dz_t a);
        logic [SCALE_PROD_W-1:0] frac;
        logic [SCALED_W-1:0]     q;
        frac = SCALE_PROD_W'(a.mag) * SCALE_PROD_W'(SCALE_RECIP);
        q    = SCALED_W'(a.mag) * SCALED_W'(SCALE_INT) + SCALED_W'(frac >> SCALE_SHIFT);
        return a.neg ? $signed(-q) : $signed(q);
    endfunction

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb begin
        s1_next.lx = dead_band(lx, dead_zone, 1'b0);
        s1_next.ly = dead_band(ly, dead_zone, 1'b0);
        s1_next.rx = dead_band(rx, dead_zone, 1'b1);
        s2_next.lx = scale_axis(s1_reg.lx);
        s2_next.ly = scale_axis(s1_reg.ly);
        s2_next.rx = scale_axis(s1_reg.rx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_axes  = s2_reg;

    `OMNI3_ASSERT_IMPLY(a_scaled_range, s2_valid_reg,
        (s2_reg.lx <= SCALE_MAX) && (s2_reg.lx >= -SCALE_MAX) &&
        (s2_reg.ly <= SCALE_MAX) && (s2_reg.ly >= -SCALE_MAX) &&
        (s2_reg.rx <= SCALE_MAX) && (s2_reg.rx >= -SCALE_MAX),
        "scaled axis outside the stick range")
    `OMNI3_ASSERT_NEXT(a_stall_hold, s2_valid_reg && !out_ready,
        s2_valid_reg && $stable(s2_reg), "stalled scaled axes changed")

endmodule

// ===== sv/omni3_mix.sv =====
`timescale 1ns / 1ps

module omni3_mix import omni3_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [ARM_W-1:0] arm_length,
    input  logic             in_valid,
    output logic             in_ready,
    input  axes_t            in_axes,
    output logic             out_valid,
    input  logic             out_ready,
    output prod_t            out_prod
);

    // Stage 3 rotates the left vector and forms the turn term; stage 4 forms
    // the Q32 products of the wheel equations.
    logic  s3_valid_reg;
    logic  s3_ready;
    rot_t  s3_reg;
    rot_t  s3_next;
    logic  s4_valid_reg;
    logic  s4_ready;
    prod_t s4_reg;
    prod_t s4_next;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign in_ready = s3_ready;

    always_comb begin
        s3_next.vx   = ROT_W'(COS30_Q16) * ROT_W'(in_axes.ly)
                     - (ROT_W'(in_axes.lx) <<< HALF_SHIFT);
        s3_next.vy   = ROT_W'(COS30_Q16) * ROT_W'(in_axes.lx)
                     + (ROT_W'(in_axes.ly) <<< HALF_SHIFT);
        s3_next.turn = TURN_W'($signed({1'b0, arm_length})) * TURN_W'(in_axes.rx);
        s4_next.cvy  = PROD_W'(COS30_Q16) * PROD_W'(s3_reg.vy);
        s4_next.hvx  = PROD_W'(s3_reg.vx) <<< HALF_SHIFT;
        s4_next.vxs  = PROD_W'(s3_reg.vx) <<< ONE_SHIFT;
        s4_next.turn = s3_reg.turn;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (s3_ready) begin
                s3_valid_reg <= in_valid;
            end
            if (s4_ready) begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && in_valid) begin
            s3_reg <= s3_next;
        end
        if (s4_ready && s3_valid_reg) begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_prod  = s4_reg;

endmodule

// ===== sv/omni3_wheel_out.sv =====
`timescale 1ns / 1ps
`include "omni_three_wheel_kinematics_core_defines.svh"

module omni3_wheel_out import omni3_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [LIM_W-1:0] speed_limit,
    input  logic             in_valid,
    output logic             in_ready,
    input  prod_t            in_prod,
    output logic             out_valid,
    input  logic             out_ready,
    output wheels_t          out_wheels
);

    // Stage 5 sums the Q32 wheel speeds; stage 6 truncates, saturates and
    // splits each speed into magnitude and direction. Stage 6 is the output
    // register of the core.
    logic    s5_valid_reg;
    logic    s5_ready;
    wsum_t   s5_reg;
    wsum_t   s5_next;
    logic    s6_valid_reg;
    logic    s6_ready;
    wheels_t s6_reg;
    wheels_t s6_next;
    logic signed [SUM_W-1:0] turn_q32;

    function automatic wheel_t finish(input logic signed [SUM_W-1:0] w,
                                      input logic [LIM_W-1:0] lim);
        wheel_t                    r;
        logic signed [WHOLE_W-1:0] q;
        logic signed [WHOLE_W-1:0] lim_s;
        logic                      round_up;
        // Arithmetic shift floors; negative values with a fraction step back
        // up by one so the division truncates toward zero.
        round_up = w[SUM_W-1] && (|w[FRAC_W-1:0]);
        q        = $signed(w[SUM_W-1:FRAC_W]) + $signed({{(WHOLE_W-1){1'b0}}, round_up});
        lim_s    = WHOLE_W'($signed({1'b0, lim}));
        if (q > lim_s) begin
            q = lim_s;
        end
        if (q < -lim_s) begin
            q = -lim_s;
        end
        r.rev   = q[WHOLE_W-1];
        r.speed = q[WHOLE_W-1] ? SPEED_W'(-q) : SPEED_W'(q);
        return r;
    endfunction

    assign s6_ready = !s6_valid_reg || out_ready;
    assign s5_ready = !s5_valid_reg || s6_ready;
    assign in_ready = s5_ready;

    assign turn_q32 = SUM_W'(in_prod.turn) <<< FRAC_W;

    always_comb begin
        s5_next.front      = SUM_W'(in_prod.cvy) - SUM_W'(in_prod.hvx) + turn_q32;
        s5_next.rear_right = -SUM_W'(in_prod.cvy) - SUM_W'(in_prod.hvx) + turn_q32;
        s5_next.rear_left  = SUM_W'(in_prod.vxs) + turn_q32;
        s6_next.front      = finish(s5_reg.front, speed_limit);
        s6_next.rear_right = finish(s5_reg.rear_right, speed_limit);
        s6_next.rear_left  = finish(s5_reg.rear_left, speed_limit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else begin
            if (s5_ready) begin
                s5_valid_reg <= in_valid;
            end
            if (s6_ready) begin
                s6_valid_reg <= s5_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_ready && in_valid) begin
            s5_reg <= s5_next;
        end
        if (s6_ready && s5_valid_reg) begin
            s6_reg <= s6_next;
        end
    end

    assign out_valid  = s6_valid_reg;
    assign out_wheels = s6_reg;

    `OMNI3_ASSERT_IMPLY(a_reverse_nonzero, s6_valid_reg,
        (!s6_reg.front.rev || s6_reg.front.speed != '0) &&
        (!s6_reg.rear_right.rev || s6_reg.rear_right.speed != '0) &&
        (!s6_reg.rear_left.rev || s6_reg.rear_left.speed != '0),
        "reverse flag set on a zero wheel speed")

endmodule

// ===== sv/omni_three_wheel_kinematics_core.sv =====
// Each accepted input transaction passes through all six stages to reach m_axis.
// Throughput: one transaction per cycle if m_axis is ready; each stage holds its
// data under backpressure, so a stall stops the pipeline without loss or repetition.
// Reset (aresetn low, synchronous): all stage valid bits clear and the registers
// return to dead_zone 50, arm_length 310 and speed_limit 800.
`timescale 1ns / 1ps
`include "omni_three_wheel_kinematics_core_defines.svh"

// Three-wheel omni drive inverse kinematics. Each input transaction carries one
// joystick sample; each output transaction carries the three wheel speeds.
//
// Pipeline:
//   stage 1  dead zone on both left axes, dead zone with offset removal on the
//            right x axis (turn rate)
//   stage 2  scale every axis by 950/127, truncating toward zero
//   stage 3  rotate the left vector by -30 degrees (Q1.16) and form
//            arm_length times the turn rate
//   stage 4  Q32 products of the wheel equations
//   stage 5  front, rear right and rear left sums in Q32
//   stage 6  truncate toward zero, saturate to +/- speed_limit, split into
//            magnitude and reverse bit; this is the output register
//
// Every stage has its own valid bit and is ready when it is empty or when the
// stage after it is ready, so the core keeps accepting samples while a finished
// result waits on m_axis as long as there is an empty stage to fill.
//
// The configuration registers are meant to be written only while the pipeline
// is empty. Writes to an index past the last register are accepted and dropped.
module omni_three_wheel_kinematics_core import omni3_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // Joystick samples.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] stick_left_x, [15:8] stick_left_y, [23:16] stick_right_x
    input  logic [23:0]           s_axis_tdata,

    // Wheel speeds.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [9:0] front_speed, [10] front_reverse, [20:11] rear_right_speed,
    // [21] rear_right_reverse, [31:22] rear_left_speed, [32] rear_left_reverse,
    // [39:33] zero
    output logic [39:0]           m_axis_tdata
);

    logic [DZ_W-1:0]  dead_zone_reg;
    logic [ARM_W-1:0] arm_length_reg;
    logic [LIM_W-1:0] speed_limit_reg;

    logic    cond_valid;
    logic    cond_ready;
    axes_t   cond_axes;
    logic    mix_valid;
    logic    mix_ready;
    prod_t   mix_prod;
    wheels_t wheels;

    // The configuration channel never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_zone_reg   <= DEAD_ZONE_RST;
            arm_length_reg  <= ARM_LENGTH_RST;
            speed_limit_reg <= SPEED_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DEAD_ZONE: begin
                    dead_zone_reg <= cfg_data[DZ_W-1:0];
                end
                CFG_ARM_LENGTH: begin
                    arm_length_reg <= cfg_data[ARM_W-1:0];
                end
                CFG_SPEED_LIMIT: begin
                    speed_limit_reg <= cfg_data[LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stages 1 and 2: dead zone and scaling.
    omni3_axis_cond u_axis_cond (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dead_zone (dead_zone_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .lx        ($signed(s_axis_tdata[7:0])),
        .ly        ($signed(s_axis_tdata[15:8])),
        .rx        ($signed(s_axis_tdata[23:16])),
        .out_valid (cond_valid),
        .out_ready (cond_ready),
        .out_axes  (cond_axes)
    );

    // Stages 3 and 4: rotation, turn term and wheel products.
    omni3_mix u_mix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .arm_length (arm_length_reg),
        .in_valid   (cond_valid),
        .in_ready   (cond_ready),
        .in_axes    (cond_axes),
        .out_valid  (mix_valid),
        .out_ready  (mix_ready),
        .out_prod   (mix_prod)
    );

    // Stages 5 and 6: wheel sums, truncation and saturation.
    omni3_wheel_out u_wheel_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .speed_limit (speed_limit_reg),
        .in_valid    (mix_valid),
        .in_ready    (mix_ready),
        .in_prod     (mix_prod),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_wheels  (wheels)
    );

    assign m_axis_tdata = {7'd0,
                           wheels.rear_left.rev, wheels.rear_left.speed,
                           wheels.rear_right.rev, wheels.rear_right.speed,
                           wheels.front.rev, wheels.front.speed};

    // A write to an index past the register list must leave every register alone.
    `OMNI3_ASSERT_NEXT(a_cfg_unknown_index,
        cfg_valid && !(cfg_index == CFG_DEAD_ZONE || cfg_index == CFG_ARM_LENGTH ||
                       cfg_index == CFG_SPEED_LIMIT),
        $stable(dead_zone_reg) && $stable(arm_length_reg) && $stable(speed_limit_reg),
        "configuration changed by a write to an unused index")

endmodule

// ===== tb/wheel_speed_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration channel, the joystick stream and the wheel speed
// stream. Each accepted sample gets a predicted set of wheel speeds, and each
// result is compared against the oldest prediction still waiting.
module wheel_speed_checker import omni3_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [39:0]           m_axis_tdata,
    output int                    mismatch_count,
    output int                    results_pending
);

    localparam longint AXIS_GAIN_NUM = 950;
    localparam longint AXIS_GAIN_DEN = 127;
    localparam longint ROT_COS       = 56756;
    localparam longint ROT_HALF      = 32768;
    localparam longint Q16_UNIT      = 64'sd65536;
    localparam longint Q32_UNIT      = 64'sd4294967296;
    localparam int     REPORT_LIMIT  = 10;

    // Same field order as m_axis_tdata, lowest bits last in the declaration.
    typedef struct packed {
        logic               rear_left_reverse;
        logic [SPEED_W-1:0] rear_left_speed;
        logic               rear_right_reverse;
        logic [SPEED_W-1:0] rear_right_speed;
        logic               front_reverse;
        logic [SPEED_W-1:0] front_speed;
    } wheel_speeds_t;

    logic [DZ_W-1:0]  dz_cfg;
    logic [ARM_W-1:0] arm_cfg;
    logic [LIM_W-1:0] limit_cfg;
    wheel_speeds_t    expected_speeds[$];
    int               fail_count = 0;

    initial begin
        mismatch_count  = 0;
        results_pending = 0;
    end

    // Truncates a Q32 speed toward zero, clamps it and splits off the sign.
    function automatic logic [SPEED_W:0] saturate_wheel(input longint q32);
        longint whole;
        longint lim;
        longint mag;
        whole = q32 / Q32_UNIT;
        lim = longint'(limit_cfg);
        if (whole > lim)
            whole = lim;
        if (whole < -lim)
            whole = -lim;
        if (whole < 0) begin
            mag = -whole;
            return {1'b1, mag[SPEED_W-1:0]};
        end
        mag = whole;
        return {1'b0, mag[SPEED_W-1:0]};
    endfunction

    function automatic wheel_speeds_t predict_wheels(input logic signed [7:0] lx_in,
                                                     input logic signed [7:0] ly_in,
                                                     input logic signed [7:0] rx_in);
        longint dz;
        longint arm;
        longint lx;
        longint ly;
        longint rx;
        longint vx16;
        longint vy16;
        longint turn;
        wheel_speeds_t w;
        dz = longint'(dz_cfg);
        arm = longint'(arm_cfg);
        lx = longint'(lx_in);
        ly = longint'(ly_in);
        rx = longint'(rx_in);
        if ((lx < 0 ? -lx : lx) < dz)
            lx = 0;
        if ((ly < 0 ? -ly : ly) < dz)
            ly = 0;
        // The turn axis also loses the dead zone width outside of it.
        if ((rx < 0 ? -rx : rx) < dz)
            rx = 0;
        else if (rx > 0)
            rx = rx - dz;
        else
            rx = rx + dz;
        lx = (lx * AXIS_GAIN_NUM) / AXIS_GAIN_DEN;
        ly = (ly * AXIS_GAIN_NUM) / AXIS_GAIN_DEN;
        rx = (rx * AXIS_GAIN_NUM) / AXIS_GAIN_DEN;
        vx16 = -ROT_HALF * lx + ROT_COS * ly;
        vy16 = ROT_COS * lx + ROT_HALF * ly;
        turn = arm * rx * Q32_UNIT;
        {w.front_reverse, w.front_speed} =
            saturate_wheel(-ROT_HALF * vx16 + ROT_COS * vy16 + turn);
        {w.rear_right_reverse, w.rear_right_speed} =
            saturate_wheel(-ROT_HALF * vx16 - ROT_COS * vy16 + turn);
        {w.rear_left_reverse, w.rear_left_speed} =
            saturate_wheel(vx16 * Q16_UNIT + turn);
        return w;
    endfunction

    always @(posedge aclk) begin
        wheel_speeds_t got;
        wheel_speeds_t want;
        if (!aresetn) begin
            dz_cfg    = DEAD_ZONE_RST;
            arm_cfg   = ARM_LENGTH_RST;
            limit_cfg = SPEED_LIMIT_RST;
            expected_speeds.delete();
        end else begin
            // Results are retired before new samples are queued, so a result and
            // a sample in the same cycle never meet in the queue.
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[32:0];
                if (expected_speeds.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: wheel speeds %h arrived with nothing expected",
                                 $realtime, m_axis_tdata);
                end else begin
                    want = expected_speeds.pop_front();
                    if (got.front_speed !== want.front_speed
                            || got.front_reverse !== want.front_reverse
                            || got.rear_right_speed !== want.rear_right_speed
                            || got.rear_right_reverse !== want.rear_right_reverse
                            || got.rear_left_speed !== want.rear_left_speed
                            || got.rear_left_reverse !== want.rear_left_reverse) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"%0t: wheel speed mismatch, expected f %0d/%0b ",
                                      "rr %0d/%0b rl %0d/%0b, got f %0d/%0b rr %0d/%0b ",
                                      "rl %0d/%0b"}, $realtime,
                                     want.front_speed, want.front_reverse,
                                     want.rear_right_speed, want.rear_right_reverse,
                                     want.rear_left_speed, want.rear_left_reverse,
                                     got.front_speed, got.front_reverse,
                                     got.rear_right_speed, got.rear_right_reverse,
                                     got.rear_left_speed, got.rear_left_reverse);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_speeds.push_back(predict_wheels(s_axis_tdata[7:0],
                                                         s_axis_tdata[15:8],
                                                         s_axis_tdata[23:16]));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEAD_ZONE:   dz_cfg    = cfg_data[DZ_W-1:0];
                    CFG_ARM_LENGTH:  arm_cfg   = cfg_data[ARM_W-1:0];
                    CFG_SPEED_LIMIT: limit_cfg = cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
        end
        mismatch_count  <= fail_count;
        results_pending <= expected_speeds.size();
    end

endmodule

// ===== tb/omni_three_wheel_kinematics_core_test.sv =====
`timescale 1ns / 1ps

// Top of the kinematics core test. This module only produces stimulus and
// gives the verdict; prediction and comparison live in wheel_speed_checker.
//
// The run starts with a short directed part under three register settings
// (reset values, zero dead zone with the widest arm and limit, and the widest
// dead zone with a zero limit), followed by six random phases. Each phase
// writes all three registers while the pipeline is empty and then streams
// joystick samples biased toward the stick extremes and the dead zone edges.
module omni_three_wheel_kinematics_core_test;
    import omni3_pkg::*;

    localparam int PHASE_ITEMS  = 180;
    localparam int PHASE_COUNT  = 6;
    // The pipeline is six stages deep; a few spare cycles cover any slack.
    localparam int SETTLE_CYCLES = 12;
    // Length of the deliberate receiver hold-off.
    localparam int HOLD_CYCLES  = 300;
    // Cycles without any transaction before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    // Index past the last register; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;

    int mismatch_count;
    int results_pending;
    int quiet_cycles = 0;
    int dz_now       = int'(DEAD_ZONE_RST);
    // Both sides idle at random while this is set; the last phase clears it.
    bit idle_on      = 1'b1;
    // Set by the stimulus to make the receiver hold off for a long stretch.
    bit hold_request = 1'b0;

    always #5 aclk = ~aclk;

    omni_three_wheel_kinematics_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    wheel_speed_checker wheel_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Watchdog: any transaction on any channel restarts the count.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver. It alternates ready runs with random stall bursts, and on
    // request holds off long enough for the pipeline to fill and push back on
    // the sample stream.
    initial begin
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // Offers one sample and returns at the edge where the transaction happens.
    // Valid stays high so that a following sample goes out back to back,
    // unless a random gap is inserted.
    task automatic send_sample(input int lx, input int ly, input int rx);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rx[7:0], ly[7:0], lx[7:0]};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    // Stops the sample stream and waits until every predicted result has
    // arrived, then lets the pipeline settle. The first edge lets the queue
    // count catch up with the last sample.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes all three registers back to back, preceded by a write to the
    // spare index that the core has to drop. Only called with the pipeline empty.
    task automatic configure(input int dz_word, input int arm, input int lim);
        logic [CFG_IDX_W-1:0]  idx_list[4];
        logic [CFG_DATA_W-1:0] val_list[4];
        idx_list = '{CFG_SPARE_IDX, CFG_DEAD_ZONE, CFG_ARM_LENGTH, CFG_SPEED_LIMIT};
        val_list = '{CFG_DATA_W'($urandom_range(0, 1023)), CFG_DATA_W'(dz_word),
                     CFG_DATA_W'(arm), CFG_DATA_W'(lim)};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= val_list[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        dz_now = dz_word & 127;
        @(posedge aclk);
    endtask

    // Stick values: extremes, the dead zone edges on both sides, or anything.
    function automatic int pick_axis();
        case ($urandom_range(0, 9))
            0: return 127;
            1: return -128;
            2: return 0;
            3: return dz_now;
            4: return -dz_now;
            5: return dz_now - 1;
            6: return 1 - dz_now;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    initial begin
        int dz;
        int arm;
        int lim;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: stick extremes, the dead zone boundary on every axis,
        // and the turn axis alone at both ends.
        send_sample(0, 0, 0);
        send_sample(127, 127, 127);
        send_sample(-128, -128, -128);
        send_sample(127, -128, 50);
        send_sample(-128, 127, -50);
        send_sample(49, -49, 49);
        send_sample(50, -50, -49);
        send_sample(0, 0, 127);
        send_sample(0, 0, -128);
        send_sample(-1, -1, -1);
        wait_for_results();

        // A zero dead zone, written with its unused upper bits set so they must
        // be dropped. Sample (2, 1, 0) gives a rear left speed just below zero
        // that truncates to zero and must not show a reverse bit.
        configure(10'h380, 1023, 1023);
        send_sample(2, 1, 0);
        send_sample(-2, -1, 0);
        send_sample(1, 1, 1);
        send_sample(-1, -1, -1);
        send_sample(127, 127, 127);
        send_sample(-128, -128, -128);
        send_sample(0, 0, -128);
        send_sample(-128, 127, 127);
        wait_for_results();

        // Widest dead zone with a zero speed limit: every wheel reads zero.
        configure(127, 0, 0);
        send_sample(127, -128, 127);
        send_sample(-128, 127, -128);
        send_sample(-127, 0, 126);
        send_sample(0, 0, 0);
        wait_for_results();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case ($urandom_range(0, 3))
                0: dz = 0;
                1: dz = 127;
                default: dz = $urandom_range(0, 127);
            endcase
            case ($urandom_range(0, 3))
                0: arm = 0;
                1: arm = 1023;
                default: arm = $urandom_range(0, 1023);
            endcase
            case ($urandom_range(0, 7))
                0: lim = 0;
                1, 2: lim = 1023;
                default: lim = $urandom_range(0, 1023);
            endcase
            configure(($urandom_range(0, 7) << 7) | dz, arm, lim);

            // The last phase runs without any idling on either side.
            if (phase == PHASE_COUNT - 1)
                idle_on = 1'b0;
            // In the second phase the receiver holds off while samples keep
            // coming, so the core fills and stalls its input.
            if (phase == 1)
                hold_request = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_axis(), pick_axis(), pick_axis());
            wait_for_results();
        end

        if (mismatch_count == 0 && results_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== omni_three_wheel_kinematics_core.f =====
+incdir+sv
sv/omni3_pkg.sv
sv/omni3_axis_cond.sv
sv/omni3_mix.sv
sv/omni3_wheel_out.sv
sv/omni_three_wheel_kinematics_core.sv
tb/wheel_speed_checker.sv
tb/omni_three_wheel_kinematics_core_test.sv
